// File: hw/rtl/button_short_long_press_classifier_core_macros.svh
// assertion macros used by the checker file
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_CORE_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define BSLP_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked implication, disabled while reset is asserted
`define BSLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bslp_pkg.sv
package bslp_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_HOLD_MS     = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_POLL_INTERVAL_MS = 1'b1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_LONG_HOLD_MS     = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] RST_POLL_INTERVAL_MS = 16'd50;

    // command codes carried in tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // stream widths
    localparam int TIME_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // one input item
    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic              button_level;
        logic              read_ok;
    } bslp_item_t;

    // one result item
    typedef struct packed {
        logic short_press;
        logic long_press;
        logic release_res;
        logic level_known;
    } bslp_result_t;

endpackage

// File: hw/rtl/bslp_in_reg.sv
module bslp_in_reg
    import bslp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 advance,
    output logic                 valid,
    output bslp_item_t           item
);

    logic       valid_reg;
    bslp_item_t item_reg;

    // take a new item when empty or when the held one moves on
    assign s_tready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign item     = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // payload capture, unpacked from the stream fields
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.command      <= s_tuser;
            item_reg.now_ms       <= s_tdata[TIME_W-1:0];
            item_reg.button_level <= s_tdata[TIME_W];
            item_reg.read_ok      <= s_tdata[TIME_W+1];
        end
    end

endmodule

// File: hw/rtl/bslp_engine.sv
module bslp_engine
    import bslp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  fire,
    input  bslp_item_t            item,
    output bslp_result_t          result
);

    logic [CFG_DATA_W-1:0] long_hold_reg;
    logic [CFG_DATA_W-1:0] poll_interval_reg;

    logic              prev_level_reg,      prev_level_next;
    logic              level_valid_reg,     level_valid_next;
    logic [TIME_W-1:0] press_start_reg,     press_start_next;
    logic              long_done_reg,       long_done_next;
    logic [TIME_W-1:0] last_poll_reg,       last_poll_next;
    logic              short_pending_reg,   short_pending_next;
    logic              long_pending_reg,    long_pending_next;
    logic              release_pending_reg, release_pending_next;

    logic [TIME_W-1:0] since_poll;
    logic [TIME_W-1:0] held_ms;
    logic              poll_due;
    logic              hold_reached;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg     <= RST_LONG_HOLD_MS;
            poll_interval_reg <= RST_POLL_INTERVAL_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LONG_HOLD_MS:     long_hold_reg     <= cfg_wdata;
                REG_POLL_INTERVAL_MS: poll_interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // wrapping distances and threshold compares
    assign since_poll   = item.now_ms - last_poll_reg;
    assign held_ms      = item.now_ms - press_start_reg;
    assign poll_due     = since_poll >= {{(TIME_W-CFG_DATA_W){1'b0}}, poll_interval_reg};
    assign hold_reached = held_ms >= {{(TIME_W-CFG_DATA_W){1'b0}}, long_hold_reg};

    // poll, seed and edge classification
    always_comb
    begin
        prev_level_next      = prev_level_reg;
        level_valid_next     = level_valid_reg;
        press_start_next     = press_start_reg;
        long_done_next       = long_done_reg;
        last_poll_next       = last_poll_reg;
        short_pending_next   = short_pending_reg;
        long_pending_next    = long_pending_reg;
        release_pending_next = release_pending_reg;

        if (item.command == CMD_TICK && poll_due)
        begin
            last_poll_next = item.now_ms;
            if (item.read_ok)
            begin
                prev_level_next = item.button_level;
                if (!level_valid_reg)
                begin
                    level_valid_next = 1'b1;
                end
                else if (item.button_level && !prev_level_reg)
                begin
                    press_start_next = item.now_ms;
                    long_done_next   = 1'b0;
                end
                else if (item.button_level && prev_level_reg)
                begin
                    if (!long_done_reg && hold_reached)
                    begin
                        long_pending_next = 1'b1;
                        long_done_next    = 1'b1;
                    end
                end
                else if (!item.button_level && prev_level_reg)
                begin
                    release_pending_next = 1'b1;
                    if (!long_done_reg)
                    begin
                        short_pending_next = 1'b1;
                    end
                end
            end
        end

        // a tick reports updated flags, a fetch reports them before the clear
        result.short_press = short_pending_next;
        result.long_press  = long_pending_next;
        result.release_res = release_pending_next;
        result.level_known = level_valid_next;

        if (item.command == CMD_FETCH)
        begin
            short_pending_next   = 1'b0;
            long_pending_next    = 1'b0;
            release_pending_next = 1'b0;
        end
    end

    // classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg      <= 1'b0;
            level_valid_reg     <= 1'b0;
            press_start_reg     <= '0;
            long_done_reg       <= 1'b0;
            last_poll_reg       <= '0;
            short_pending_reg   <= 1'b0;
            long_pending_reg    <= 1'b0;
            release_pending_reg <= 1'b0;
        end
        else if (fire)
        begin
            prev_level_reg      <= prev_level_next;
            level_valid_reg     <= level_valid_next;
            press_start_reg     <= press_start_next;
            long_done_reg       <= long_done_next;
            last_poll_reg       <= last_poll_next;
            short_pending_reg   <= short_pending_next;
            long_pending_reg    <= long_pending_next;
            release_pending_reg <= release_pending_next;
        end
    end

endmodule

// File: hw/rtl/bslp_out_reg.sv
module bslp_out_reg
    import bslp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  bslp_result_t         result,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic         valid_reg;
    bslp_result_t result_reg;

    // free when empty or when the held item is taken this cycle
    assign advance  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-4){1'b0}}, result_reg.level_known, result_reg.release_res,
                       result_reg.long_press, result_reg.short_press};

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (in_valid && advance)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: hw/rtl/button_short_long_press_classifier_core.sv
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: command; tdata: now_ms, button_level, read_ok
// m_*       out  m_tvalid/m_tready    tdata: short_press, long_press, release_res, level_known
// cfg_*     in   cfg_we               cfg_addr: register index; cfg_wdata: 16-bit value
//
// one item per clock while the result is not stalled; an accepted item waits in the input
// register, and its result is captured in the result register once that register is free
// the classifier state is one compare and subtract deep between input and result registers
// rst_n clears valid flags, classifier state and loads register defaults (1500, 50)
// a stalled result holds the pipe; input stays ready while either stage can move
module button_short_long_press_classifier_core
    import bslp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms, [32] button_level, [33] read_ok
    input  logic                  s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] short_press, [1] long_press,
                                             // [2] release_res, [3] level_known
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic         advance;
    logic         in_valid;
    bslp_item_t   item;
    bslp_result_t result;

    // input register
    bslp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .valid    (in_valid),
        .item     (item)
    );

    // state update and result logic
    bslp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (in_valid && advance),
        .item      (item),
        .result    (result)
    );

    // result register
    bslp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .result   (result),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: hw/rtl/bslp_checker.sv
`include "button_short_long_press_classifier_core_macros.svh"

module bslp_checker
    import bslp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result stays offered
    `BSLP_ASSERT_IMP(a_out_hold, m_tvalid && !m_tready, ##1 m_tvalid, "stalled result dropped")

    // a stalled result keeps its payload
    `BSLP_ASSERT_IMP(a_out_stable, m_tvalid && !m_tready, ##1 $stable(m_tdata), "payload changed")

    // input back-pressure only comes from a stalled output
    `BSLP_ASSERT_IMP(a_ready_cause, !s_tready, m_tvalid && !m_tready, "ready low, no stall")

    // an item accepted while no result is offered shows up as an offered result
    `BSLP_ASSERT_IMP(a_latency, s_tvalid && s_tready && !m_tvalid, ##2 m_tvalid, "result missing")

endmodule

bind button_short_long_press_classifier_core bslp_checker u_bslp_checker (.*);
